// ===== src/isqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// isqrt_pkg
// Shared constants for the Newton integer square root block.
// ----------------------------------------------------------------------------
package isqrt_pkg;

  // Default radicand width
  localparam int DEF_DATA_WIDTH = 31;

  // Width of the root field on the result stream
  localparam int ROOT_W = 16;

endpackage

// ===== src/isqrt_div.sv =====
// ----------------------------------------------------------------------------
// isqrt_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse
// loads the operands; done pulses once the quotient is valid. The quotient
// holds until the next start.
// ----------------------------------------------------------------------------
module isqrt_div #(
  parameter int DATA_WIDTH = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient
);

  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH:0]   rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] den;

  logic [DATA_WIDTH:0]   trial;
  logic                  fits;
  logic [DATA_WIDTH:0]   rem_next;
  logic [DATA_WIDTH-1:0] quo_next;

  // One shift-compare-subtract step
  always_comb begin
    trial    = {rem[DATA_WIDTH-1:0], quo[DATA_WIDTH-1]};
    fits     = (trial >= {1'b0, den});
    rem_next = fits ? (trial - {1'b0, den}) : trial;
    quo_next = {quo[DATA_WIDTH-2:0], fits};
  end

  // Control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

// ===== src/integer_square_root_newton.sv =====
// ----------------------------------------------------------------------------
// integer_square_root_newton
// Floor square root by Newton iteration on a shared serial divider.
//
//   Channel   Dir  Signals                       Payload
//   s_axis    in   tvalid/tready/tdata           radicand [DATA_WIDTH-1:0]
//   m_axis    out  tvalid/tready/tdata           root [15:0]
//
// Radicands 0 and 1 put their result on m_axis in the cycle after the transfer.
// Otherwise each Newton step loads the divider in ST_START, runs the
// bit-serial division in ST_DIV and updates the estimate on div_done;
// iteration stops once the new estimate is not below the current one.
// One item is in flight at a time; s_axis_tready is high only when idle.
// The result holds on m_axis while m_axis_tready is low.
// Synchronous active-high reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
module integer_square_root_newton #(
  parameter int DATA_WIDTH = isqrt_pkg::DEF_DATA_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // [DATA_WIDTH-1:0] radicand
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [isqrt_pkg::ROOT_W-1:0]         m_axis_tdata   // [15:0] root
);

  import isqrt_pkg::*;

  localparam int EXT_W = (DATA_WIDTH > ROOT_W) ? DATA_WIDTH : ROOT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]            state;
  logic [DATA_WIDTH-1:0] n_reg;
  logic [DATA_WIDTH-1:0] est;

  logic [DATA_WIDTH-1:0] in_n;
  logic                  in_xfer;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] quot;
  logic [DATA_WIDTH:0]   sum;
  logic [DATA_WIDTH-1:0] est_new;
  logic                  converged;
  logic [EXT_W-1:0]      est_ext;

  assign in_n    = s_axis_tdata[DATA_WIDTH-1:0];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Shared divider: radicand / current estimate
  isqrt_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (n_reg),
    .divisor  (est),
    .done     (div_done),
    .quotient (quot)
  );

  // Newton update and stop test
  always_comb begin
    sum       = {1'b0, quot} + {1'b0, est};
    est_new   = sum[DATA_WIDTH:1];
    converged = (est_new >= est);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= (in_n < DATA_WIDTH'(2)) ? ST_OUT : ST_START;
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= converged ? ST_OUT : ST_START;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Radicand and estimate registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_xfer) begin
      n_reg <= in_n;
      est   <= (in_n < DATA_WIDTH'(2)) ? in_n : (in_n >> 1);
    end else if (state == ST_DIV && div_done && !converged) begin
      est <= est_new;
    end
  end

  // Handshakes and result
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign est_ext       = EXT_W'(est);
  assign m_axis_tdata  = est_ext[ROOT_W-1:0];

endmodule
